>>> design/dwm_pkg.sv
// ----------------------------------------------------------------------------
// dwm_pkg: shared types and constants of the distinct window marker finder
// Request structs for the letter and result channels, field widths and the
// reset value of the window size register.
// ----------------------------------------------------------------------------
package dwm_pkg;

  // field widths fixed by the channel definitions
  localparam int unsigned LetterWidth  = 5;
  localparam int unsigned WsizeWidth   = 5;
  localparam int unsigned PosWidth     = 17;

  // window size after reset
  localparam logic [WsizeWidth-1:0] WsizeReset = WsizeWidth'(4);

  // one letter of a line
  typedef struct packed {
    logic [LetterWidth-1:0] letter;
    logic                   end_of_line;
  } in_req_t;

  // one marker or line-end report
  typedef struct packed {
    logic                found;
    logic [PosWidth-1:0] marker_position;
  } out_req_t;

endpackage

>>> design/dwm_distinct.sv
// ----------------------------------------------------------------------------
// dwm_distinct: all-different check over the active window
// Pairwise compare of every letter slot against every older slot; a pair only
// counts when both slots fall inside the active window size.
// ----------------------------------------------------------------------------
module dwm_distinct #(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned EFF_WIDTH  = 5
) (
  input  logic [MAX_WINDOW-1:0][dwm_pkg::LetterWidth-1:0] win_i,
  input  logic [EFF_WIDTH-1:0]                            wsize_i,
  output logic                                            distinct_o
);

  // pairwise equality, masked to slots below the window size
  always_comb begin
    distinct_o = 1'b1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      for (int j = i + 1; j < MAX_WINDOW; j++) begin
        if ((EFF_WIDTH'(j) < wsize_i) && (win_i[i] == win_i[j])) begin
          distinct_o = 1'b0;
        end
      end
    end
  end

endmodule

>>> design/distinct_window_marker_finder_core.sv
// ----------------------------------------------------------------------------
// distinct_window_marker_finder_core: first all-different window in a line
// Takes letters of a line one request at a time and reports once where the
// last window_size letters first all differ, or the line length if never.
// ----------------------------------------------------------------------------
// Usage
//   in channel:  in_valid_i / in_ready_o with one letter and an end-of-line
//                flag per request; the flag marks the last letter of a line.
//   out channel: out_valid_o / out_ready_i with found and marker_position;
//                at most one result request per letter.
//   cfg port:    cfg_we_i writes the window size (1..MAX_WINDOW, 0 acts as
//                1, larger acts as MAX_WINDOW); write only while idle.
// Timing
//   a letter is captured in the input register, evaluated combinationally
//   against the letter history, and its result lands in the output register.
//   throughput is one letter per cycle while out_ready_i stays high, set by
//   the combinational pairwise compare and the one-entry output register.
// Reset and stalls
//   reset clears the history, the letter count and the reported flag and
//   sets the window size to 4. when the receiver stalls with a result
//   pending, the input register fills and in_ready_o drops.
module distinct_window_marker_finder_core #(
  parameter int unsigned MAX_WINDOW      = 16,
  parameter int unsigned MAX_LINE_LENGTH = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dwm_pkg::in_req_t                     in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dwm_pkg::out_req_t                    out_req_o,
  input  logic                                 cfg_we_i,
  input  logic [dwm_pkg::WsizeWidth-1:0]       cfg_wdata_i
);

  localparam int unsigned WinWidth = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EffWidth = (WinWidth > dwm_pkg::WsizeWidth) ?
                                     WinWidth : dwm_pkg::WsizeWidth;
  localparam int unsigned CntWidth = $clog2(MAX_LINE_LENGTH + 1);
  localparam int unsigned GeWidth  = (CntWidth > EffWidth) ? CntWidth : EffWidth;
  localparam int unsigned ExtWidth = (CntWidth > dwm_pkg::PosWidth) ?
                                     CntWidth : dwm_pkg::PosWidth;
  localparam int unsigned HistDepth = MAX_WINDOW - 1;

  localparam logic [CntWidth-1:0] MaxCount  = CntWidth'(MAX_LINE_LENGTH);
  localparam logic [EffWidth-1:0] MaxWsize  = EffWidth'(MAX_WINDOW);
  localparam logic [EffWidth-1:0] MinWsize  = EffWidth'(1);

  logic [dwm_pkg::WsizeWidth-1:0] wsize_q;
  logic                           s1_valid_q, s1_valid_d;
  dwm_pkg::in_req_t               s1_req_q;
  logic [HistDepth-1:0][dwm_pkg::LetterWidth-1:0] hist_q, hist_d;
  logic [CntWidth-1:0]            seen_q, seen_d;
  logic                           reported_q, reported_d;
  logic                           out_valid_q, out_valid_d;
  dwm_pkg::out_req_t              out_req_q, out_req_d;

  logic                           s1_go;
  logic [EffWidth-1:0]            wsize_ext, wsize_eff;
  logic [MAX_WINDOW-1:0][dwm_pkg::LetterWidth-1:0] win;
  logic                           distinct;
  logic [CntWidth-1:0]            seen_next;
  logic [ExtWidth-1:0]            seen_ext;
  logic                           hit;

  // window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= dwm_pkg::WsizeReset;
    end else if (cfg_we_i) begin
      wsize_q <= cfg_wdata_i;
    end
  end

  // effective window size, clamped to 1..MAX_WINDOW
  always_comb begin
    wsize_ext = EffWidth'(wsize_q);
    if (wsize_ext == '0) begin
      wsize_eff = MinWsize;
    end else if (wsize_ext > MaxWsize) begin
      wsize_eff = MaxWsize;
    end else begin
      wsize_eff = wsize_ext;
    end
  end

  // handshake between input register and output register
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
  end

  // window with the new letter at slot zero
  always_comb begin
    win[0] = s1_req_q.letter;
    for (int k = 1; k < MAX_WINDOW; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  dwm_distinct #(
    .MAX_WINDOW (MAX_WINDOW),
    .EFF_WIDTH  (EffWidth)
  ) u_distinct (
    .win_i      (win),
    .wsize_i    (wsize_eff),
    .distinct_o (distinct)
  );

  // saturating letter count and marker decision
  assign seen_next = (seen_q < MaxCount) ? (seen_q + CntWidth'(1)) : seen_q;
  assign seen_ext  = ExtWidth'(seen_next);
  assign hit       = !reported_q && (GeWidth'(seen_next) >= GeWidth'(wsize_eff)) &&
                     distinct;

  // line state and result register next values
  always_comb begin
    hist_d      = hist_q;
    seen_d      = seen_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_req_d   = out_req_q;
    if (s1_go) begin
      out_req_d.found           = hit;
      out_req_d.marker_position = seen_ext[dwm_pkg::PosWidth-1:0];
      out_valid_d               = hit || (s1_req_q.end_of_line && !reported_q);
      if (s1_req_q.end_of_line) begin
        hist_d     = '0;
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        hist_d     = win[MAX_WINDOW-2:0];
        seen_d     = seen_next;
        reported_d = reported_q || hit;
      end
    end
  end

  // line state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

>>> test/tb_distinct_window_marker_finder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_window_marker_finder_core: self-checking bench for the finder
// Feeds lines of letter codes under a range of window sizes. Random idle
// bursts appear on both channels, and one long output stall backs up the
// input. A scoreboard shifts each accepted letter through its own history,
// predicts the marker or line-end report, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_distinct_window_marker_finder_core;

  localparam int unsigned MaxWindow      = 16;
  localparam int unsigned MaxLineLength  = 65536;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned LongStall      = 300;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned PhaseItems     = 85;
  localparam int unsigned PhaseCount     = 10;
  localparam int unsigned FixedPhases    = 8;
  localparam int unsigned PressurePhase  = 4;
  localparam int unsigned TimeoutNs      = 8_000_000;
  localparam byte         CharA          = "a";

  typedef logic [dwm_pkg::LetterWidth-1:0] letter_t;
  typedef logic [dwm_pkg::WsizeWidth-1:0]  wsize_t;
  typedef logic [dwm_pkg::PosWidth-1:0]    pos_t;

  // window sizes of the fixed phases: zero, one, top, oversized and in between
  localparam wsize_t PhaseWindows [FixedPhases] = '{
    wsize_t'(0), wsize_t'(1), wsize_t'(16), wsize_t'(31),
    wsize_t'(2), wsize_t'(14), wsize_t'(17), wsize_t'(3)
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  dwm_pkg::in_req_t      in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  dwm_pkg::out_req_t     out_req_o;
  logic                  cfg_we_i;
  wsize_t                cfg_wdata_i;

  bit feed_idle_en;
  bit sink_idle_en;
  bit pressure_armed;

  // expected marker reports, built from a private copy of the line state
  class marker_scoreboard;
    letter_t               history [MaxWindow];
    int unsigned           seen;
    bit                    reported;
    wsize_t                wsize;
    dwm_pkg::out_req_t     expected_q [$];
    int unsigned           mismatches;

    function new();
      wsize      = dwm_pkg::WsizeReset;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (history[i]) history[i] = '0;
      seen     = 0;
      reported = 1'b0;
    endfunction

    function void set_window(wsize_t value);
      wsize = value;
    endfunction

    // zero acts as one, anything above the history depth as the full depth
    function int unsigned span();
      if (wsize == 0) return 1;
      if (wsize > MaxWindow) return MaxWindow;
      return wsize;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // shift in one letter; returns 1 if the letter still mattered to its line
    function bit note_letter(dwm_pkg::in_req_t req);
      int unsigned       w;
      bit                differ;
      bit                live;
      dwm_pkg::out_req_t res;
      w    = span();
      live = !reported;
      for (int i = MaxWindow - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = req.letter;
      if (seen < MaxLineLength) seen++;
      differ = 1'b1;
      for (int i = 0; i < w; i++)
        for (int j = i + 1; j < w; j++)
          if (history[i] == history[j]) differ = 1'b0;
      res.marker_position = pos_t'(seen);
      if (!reported && seen >= w && differ) begin
        reported  = 1'b1;
        res.found = 1'b1;
        expected_q.push_back(res);
      end else if (req.end_of_line && !reported) begin
        res.found = 1'b0;
        expected_q.push_back(res);
      end
      if (req.end_of_line) clear_line();
      return live;
    endfunction

    function void check_result(dwm_pkg::out_req_t got);
      dwm_pkg::out_req_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected result found=%0b pos=%0d", $time, got.found,
                   got.marker_position);
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found || got.marker_position !== want.marker_position) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display({"%0t: result mismatch: expected found=%0b pos=%0d, ",
                      "got found=%0b pos=%0d"},
                     $time, want.found, want.marker_position, got.found,
                     got.marker_position);
        end
      end
    endfunction
  endclass

  marker_scoreboard sb = new();

  distinct_window_marker_finder_core #(
    .MAX_WINDOW      (MaxWindow),
    .MAX_LINE_LENGTH (MaxLineLength)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // offer one letter request, optionally after an idle burst
  task automatic push_letter(input letter_t code, input bit eol, output bit live);
    dwm_pkg::in_req_t req;
    req.letter      = code;
    req.end_of_line = eol;
    if (feed_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    live = sb.note_letter(req);
  endtask

  task automatic send_line(input letter_t codes [$], input bit terminate,
                           output int unsigned live_count);
    bit live;
    live_count = 0;
    foreach (codes[i]) begin
      push_letter(codes[i], terminate && (i == codes.size() - 1), live);
      live_count += live;
    end
  endtask

  task automatic send_text(input string s);
    letter_t     line_q [$];
    int unsigned live_count;
    for (int i = 0; i < s.len(); i++) line_q.push_back(letter_t'(s[i] - CharA));
    send_line(line_q, 1'b1, live_count);
  endtask

  // drop valid, wait for all reports, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input wsize_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_window(value);
    cfg_we_i <= 1'b0;
  endtask

  // random lines shaped around the current window size
  task automatic run_phase(input int unsigned target);
    letter_t     line_q [$];
    letter_t     pool [32];
    letter_t     tmp;
    int unsigned w, len, mode, prefix, run, pick;
    int unsigned sent_total, live_count;
    sent_total = 0;
    w          = sb.span();
    while (sent_total < target) begin
      line_q.delete();
      mode = $urandom_range(0, 9);
      len  = $urandom_range(1, 2 * w + 8);
      case (mode)
        0, 1, 2: repeat (len) line_q.push_back(letter_t'($urandom_range(0, 25)));
        3, 4: begin
          // a few repeats, then a run of all-different codes
          foreach (pool[i]) pool[i] = letter_t'(i);
          for (int i = 31; i > 0; i--) begin
            pick       = $urandom_range(0, i);
            tmp        = pool[i];
            pool[i]    = pool[pick];
            pool[pick] = tmp;
          end
          prefix = $urandom_range(0, 6);
          run    = w + $urandom_range(0, 4);
          repeat (prefix) line_q.push_back(letter_t'($urandom_range(0, 2)));
          for (int i = 0; i < run; i++) line_q.push_back(pool[i]);
        end
        5, 6: begin
          // too few different letters to ever fill a window of two or more
          if (w < 2) repeat (len) line_q.push_back(letter_t'($urandom_range(0, 25)));
          else repeat (len) line_q.push_back(letter_t'($urandom_range(0, w - 2)));
        end
        7: repeat ($urandom_range(1, (w > 1) ? w - 1 : 1))
             line_q.push_back(letter_t'($urandom_range(0, 31)));
        8: repeat (len) line_q.push_back(letter_t'($urandom_range(0, 31)));
        default: begin
          tmp = letter_t'($urandom_range(0, 31));
          repeat (len) line_q.push_back(tmp);
        end
      endcase
      send_line(line_q, 1'b1, live_count);
      sent_total += line_q.size();
    end
    // sometimes leave a line open across the next window change
    if ($urandom_range(0, 1) == 1) begin
      line_q.delete();
      repeat ($urandom_range(1, 5)) line_q.push_back(letter_t'($urandom_range(0, 25)));
      send_line(line_q, 1'b0, live_count);
    end
  endtask

  // result side: check accepted reports, drive ready with stall bursts
  initial begin : result_sink
    int unsigned stall_left;
    bit          pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    out_ready_i   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_req_o);
      if (stall_left == 0) begin
        if (pressure_armed && !pressure_done) begin
          pressure_done = 1'b1;
          stall_left    = LongStall;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 7);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    letter_t     codes [$];
    int unsigned live_count;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    feed_idle_en   = 1'b1;
    sink_idle_en   = 1'b1;
    pressure_armed = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines at the reset window size
    send_text("abcd");
    send_text("aab");
    send_text("z");
    // codes beyond z, then a letter after the marker
    codes = '{letter_t'(31), letter_t'(30), letter_t'(29), letter_t'(28), letter_t'(0)};
    send_line(codes, 1'b1, live_count);
    // marker on the last letter
    send_text("ababcd");
    // marker, then ignored letters up to the line end
    send_text("abcdef");

    // random phases over the window settings, idling off in the last one
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      if (p < FixedPhases) write_window(PhaseWindows[p]);
      else write_window(wsize_t'($urandom_range(0, 31)));
      if (p == PressurePhase) pressure_armed = 1'b1;
      if (p == PhaseCount - 1) begin
        feed_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      run_phase(PhaseItems);
    end

    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

endmodule
